// File: rtl/core/btpc_pkg.sv
// Shared constants, types and helpers for the barometric compensation pipeline.
package btpc_pkg;

   // Register stages from request acceptance to the response register.
   localparam int unsigned PipeDepth = 78;

   localparam logic [1:0] CSR_CALIB_A = 2'd0;
   localparam logic [1:0] CSR_CALIB_B = 2'd1;
   localparam logic [1:0] CSR_CALIB_C = 2'd2;

   // Calibration coefficients, each extended to 32 bits as the math needs.
   typedef struct packed {
      logic [31:0] ac1;
      logic [31:0] ac2;
      logic [31:0] ac3;
      logic [31:0] ac4;
      logic [31:0] ac5;
      logic [31:0] ac6;
      logic [31:0] b1;
      logic [31:0] b2;
      logic [31:0] mc;
      logic [31:0] md;
   } coef_type;

   // Sign extension of a 16-bit coefficient.
   function automatic logic [31:0] sx16(input logic [15:0] v);
      sx16 = {{16{v[15]}}, v};
   endfunction

   // Arithmetic right shift of a 32-bit word.
   function automatic logic [31:0] asr32(input logic [31:0] v, input int unsigned s);
      asr32 = 32'($signed(v) >>> s);
   endfunction

   // Two's complement magnitude.
   function automatic logic [31:0] mag32(input logic [31:0] v);
      mag32 = v[31] ? (32'd0 - v) : v;
   endfunction

endpackage

// File: rtl/core/baro_temp_pressure_compensation_unit.sv
// Top level of the barometric temperature and pressure compensation pipeline.
//
// Usage: a request carries one raw temperature and one raw pressure word on
// req_raw_temp and req_raw_press, accepted when req_valid is high and req_stall
// is low. Each request yields exactly one response on rsp_temp_decicelsius,
// rsp_press_pascal and rsp_div_error, taken when rsp_valid is high and
// rsp_stall is low. A zero divisor forces both values to zero and sets the
// error flag.
// The pipeline depth is set by the two 32-stage bit-per-stage dividers plus
// the multiply stages around them. Throughput is one request per cycle
// while the receiver does not stall. The whole pipeline advances as one;
// when the receiver stalls with a valid response waiting, every stage holds
// and req_stall is raised, so nothing is lost or repeated.
// Calibration must be written through csr_write_enable, csr_index and
// csr_write_data only while the pipeline is empty; the block does not check
// it. Reset clears the calibration registers and all stage valid bits.
module baro_temp_pressure_compensation_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_write_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_raw_temp,
   input  logic [15:0] req_raw_press,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic signed [15:0] rsp_temp_decicelsius,
   output logic signed [31:0] rsp_press_pascal,
   output logic        rsp_div_error
);

   logic [63:0] calib_a_ff;
   logic [63:0] calib_b_ff;
   logic [31:0] calib_c_ff;
   btpc_pkg::coef_type coef;
   logic enable;
   logic [btpc_pkg::PipeDepth-1:0] vld_ff;

   // Calibration register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         calib_a_ff <= 64'd0;
         calib_b_ff <= 64'd0;
         calib_c_ff <= 32'd0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            btpc_pkg::CSR_CALIB_A: calib_a_ff <= csr_write_data;
            btpc_pkg::CSR_CALIB_B: calib_b_ff <= csr_write_data;
            btpc_pkg::CSR_CALIB_C: calib_c_ff <= csr_write_data[31:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      coef.ac1 = btpc_pkg::sx16(calib_a_ff[63:48]);
      coef.ac2 = btpc_pkg::sx16(calib_a_ff[47:32]);
      coef.ac3 = btpc_pkg::sx16(calib_a_ff[31:16]);
      coef.ac4 = {16'd0, calib_a_ff[15:0]};
      coef.ac5 = {16'd0, calib_b_ff[63:48]};
      coef.ac6 = {16'd0, calib_b_ff[47:32]};
      coef.b1 = btpc_pkg::sx16(calib_b_ff[31:16]);
      coef.b2 = btpc_pkg::sx16(calib_b_ff[15:0]);
      coef.mc = btpc_pkg::sx16(calib_c_ff[31:16]);
      coef.md = btpc_pkg::sx16(calib_c_ff[15:0]);
   end

   // Global pipeline enable: hold everything while a valid response is stalled.
   assign enable = !(vld_ff[btpc_pkg::PipeDepth-1] && rsp_stall);
   assign req_stall = !enable;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (enable) begin
         vld_ff <= {vld_ff[btpc_pkg::PipeDepth-2:0], req_valid};
      end
   end

   // Raw pressure travels along the pipe up to the b7 difference stage.
   logic [15:0] up_ff [0:38];
   always_ff @(posedge clock) begin
      if (enable) begin
         up_ff[0] <= req_raw_press;
         for (int i = 1; i < 39; i++) begin
            up_ff[i] <= up_ff[i-1];
         end
      end
   end

   // Stages 1-2: temperature x1.
   logic [31:0] t_x1, t_num, t_den;
   btpc_temp u_temp (
      .clock    (clock),
      .enable   (enable),
      .coef     (coef),
      .raw_temp (req_raw_temp),
      .x1       (t_x1),
      .div_num  (t_num),
      .div_den  (t_den)
   );

   // Stage 3: register divider operands in magnitude form.
   logic [31:0] tn_ff, td_ff, tx1_ff;
   logic tneg_ff, tzero_ff;
   always_ff @(posedge clock) begin
      if (enable) begin
         tn_ff <= btpc_pkg::mag32(t_num);
         td_ff <= btpc_pkg::mag32(t_den);
         tneg_ff <= t_num[31] ^ t_den[31];
         tzero_ff <= (t_den == 32'd0);
         tx1_ff <= t_x1;
      end
   end

   // Stages 4-35: temperature divider, side data delayed alongside.
   logic [31:0] tq;
   btpc_udiv u_tdiv (
      .clock  (clock),
      .enable (enable),
      .num    (tn_ff),
      .den    (td_ff),
      .quo    (tq)
   );
   logic [33:0] tside_ff [0:31];
   always_ff @(posedge clock) begin
      if (enable) begin
         tside_ff[0] <= {tneg_ff, tzero_ff, tx1_ff};
         for (int i = 1; i < 32; i++) begin
            tside_ff[i] <= tside_ff[i-1];
         end
      end
   end

   // Stage 36: b5, t and b6.
   logic [31:0] b5_in, b6_ff;
   logic [15:0] t_ff;
   logic err_ff;
   assign b5_in = tside_ff[31][31:0] + (tside_ff[31][33] ? (32'd0 - tq) : tq);
   always_ff @(posedge clock) begin
      if (enable) begin
         b6_ff <= b5_in - 32'd4000;
         t_ff <= 16'(btpc_pkg::asr32(b5_in + 32'd8, 4));
         err_ff <= tside_ff[31][32];
      end
   end

   // Stage 37: products with b6.
   logic [31:0] sq_raw_ff, ac2b6_ff, ac3b6_ff;
   logic [15:0] t2_ff;
   logic err2_ff;
   always_ff @(posedge clock) begin
      if (enable) begin
         sq_raw_ff <= b6_ff * b6_ff;
         ac2b6_ff <= coef.ac2 * b6_ff;
         ac3b6_ff <= coef.ac3 * b6_ff;
         t2_ff <= t_ff;
         err2_ff <= err_ff;
      end
   end

   // Stage 38: products with sq.
   logic [31:0] sq_w, b2sq_ff, b1sq_ff, ac2b6b_ff, ac3b6b_ff;
   logic [15:0] t3_ff;
   logic err3_ff;
   assign sq_w = btpc_pkg::asr32(sq_raw_ff, 12);
   always_ff @(posedge clock) begin
      if (enable) begin
         b2sq_ff <= coef.b2 * sq_w;
         b1sq_ff <= coef.b1 * sq_w;
         ac2b6b_ff <= ac2b6_ff;
         ac3b6b_ff <= ac3b6_ff;
         t3_ff <= t2_ff;
         err3_ff <= err2_ff;
      end
   end

   // Stage 39: b3 and the x3 term for b4.
   logic [31:0] b3num, b3mag, b3_ff, x3p_ff;
   logic [15:0] t4_ff;
   logic err4_ff;
   always_comb begin
      b3num = (coef.ac1 << 2) + btpc_pkg::asr32(b2sq_ff, 11)
            + btpc_pkg::asr32(ac2b6b_ff, 11) + 32'd2;
      b3mag = btpc_pkg::mag32(b3num) >> 2;
   end
   always_ff @(posedge clock) begin
      if (enable) begin
         b3_ff <= b3num[31] ? (32'd0 - b3mag) : b3mag;
         x3p_ff <= btpc_pkg::asr32(btpc_pkg::asr32(ac3b6b_ff, 13)
                   + btpc_pkg::asr32(b1sq_ff, 16) + 32'd2, 2) + 32'd32768;
         t4_ff <= t3_ff;
         err4_ff <= err3_ff;
      end
   end

   // Stage 40: b4 product and b7 difference.
   logic [31:0] b4raw_ff, upb3_ff;
   logic [15:0] t5_ff;
   logic err5_ff;
   always_ff @(posedge clock) begin
      if (enable) begin
         b4raw_ff <= coef.ac4 * x3p_ff;
         upb3_ff <= {16'd0, up_ff[38]} - b3_ff;
         t5_ff <= t4_ff;
         err5_ff <= err4_ff;
      end
   end

   // Stage 41: b4 and b7.
   logic [31:0] b4_ff, b7_ff;
   logic [15:0] t6_ff;
   logic err6_ff;
   always_ff @(posedge clock) begin
      if (enable) begin
         b4_ff <= b4raw_ff >> 15;
         b7_ff <= upb3_ff * 32'd50000;
         t6_ff <= t5_ff;
         err6_ff <= err5_ff;
      end
   end

   // Stage 42: dividend selection for p.
   logic [31:0] pn_ff, pd_ff;
   logic pdbl_ff, perr_ff;
   logic [15:0] t7_ff;
   always_ff @(posedge clock) begin
      if (enable) begin
         pn_ff <= b7_ff[31] ? b7_ff : (b7_ff << 1);
         pdbl_ff <= b7_ff[31];
         pd_ff <= b4_ff;
         perr_ff <= err6_ff || (b4_ff == 32'd0);
         t7_ff <= t6_ff;
      end
   end

   // Stages 43-74: pressure divider.
   logic [31:0] pq;
   btpc_udiv u_pdiv (
      .clock  (clock),
      .enable (enable),
      .num    (pn_ff),
      .den    (pd_ff),
      .quo    (pq)
   );
   logic [17:0] pside_ff [0:31];
   always_ff @(posedge clock) begin
      if (enable) begin
         pside_ff[0] <= {pdbl_ff, perr_ff, t7_ff};
         for (int i = 1; i < 32; i++) begin
            pside_ff[i] <= pside_ff[i-1];
         end
      end
   end

   // Stage 75: p and first products.
   logic [31:0] p_in, p_ff, psh_ff, m7357_ff;
   logic [17:0] s75_ff;
   assign p_in = pside_ff[31][17] ? (pq << 1) : pq;
   always_ff @(posedge clock) begin
      if (enable) begin
         p_ff <= p_in;
         psh_ff <= btpc_pkg::asr32(p_in, 8);
         m7357_ff <= (32'd0 - 32'd7357) * p_in;
         s75_ff <= pside_ff[31];
      end
   end

   // Stage 76: square of p >> 8.
   logic [31:0] p2_ff, sqp_ff, m2_ff;
   logic [17:0] s76_ff;
   always_ff @(posedge clock) begin
      if (enable) begin
         p2_ff <= p_ff;
         sqp_ff <= psh_ff * psh_ff;
         m2_ff <= m7357_ff;
         s76_ff <= s75_ff;
      end
   end

   // Stage 77: times 3038.
   logic [31:0] p3_ff, x1p_ff, m3_ff;
   logic [17:0] s77_ff;
   always_ff @(posedge clock) begin
      if (enable) begin
         p3_ff <= p2_ff;
         x1p_ff <= sqp_ff * 32'd3038;
         m3_ff <= m2_ff;
         s77_ff <= s76_ff;
      end
   end

   // Stage 78: final sum and output register.
   logic [31:0] pf_in;
   logic [15:0] tout_ff;
   logic [31:0] pout_ff;
   logic eout_ff;
   assign pf_in = p3_ff + btpc_pkg::asr32(btpc_pkg::asr32(x1p_ff, 16)
                  + btpc_pkg::asr32(m3_ff, 16) + 32'd3791, 4);
   always_ff @(posedge clock) begin
      if (enable) begin
         eout_ff <= s77_ff[16];
         tout_ff <= s77_ff[16] ? 16'd0 : s77_ff[15:0];
         pout_ff <= s77_ff[16] ? 32'd0 : pf_in;
      end
   end

   assign rsp_valid = vld_ff[btpc_pkg::PipeDepth-1];
   assign rsp_temp_decicelsius = tout_ff;
   assign rsp_press_pascal = pout_ff;
   assign rsp_div_error = eout_ff;

endmodule

// File: rtl/core/btpc_udiv.sv
// Pipelined 32-bit unsigned restoring divider, one quotient bit per stage.
module btpc_udiv (
   input  logic        clock,
   input  logic        enable,
   input  logic [31:0] num,
   input  logic [31:0] den,
   output logic [31:0] quo
);

   logic [31:0] rem_stage [0:32];
   logic [31:0] num_stage [0:32];
   logic [31:0] den_stage [0:32];

   assign rem_stage[0] = 32'd0;
   assign num_stage[0] = num;
   assign den_stage[0] = den;

   // Each stage shifts in one numerator bit and tries one subtraction.
   for (genvar g = 0; g < 32; g++) begin : g_stage
      logic [32:0] trial;
      logic [32:0] diff;
      logic [31:0] rem_ff;
      logic [31:0] num_ff;
      logic [31:0] den_ff;
      assign trial = {rem_stage[g], num_stage[g][31]};
      assign diff = trial - {1'b0, den_stage[g]};
      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff <= diff[32] ? trial[31:0] : diff[31:0];
            num_ff <= {num_stage[g][30:0], ~diff[32]};
            den_ff <= den_stage[g];
         end
      end
      assign rem_stage[g+1] = rem_ff;
      assign num_stage[g+1] = num_ff;
      assign den_stage[g+1] = den_ff;
   end

   assign quo = num_stage[32];

endmodule

// File: rtl/core/btpc_temp.sv
// Temperature front end: x1 and the signed divisor and dividend for x2.
module btpc_temp (
   input  logic               clock,
   input  logic               enable,
   input  btpc_pkg::coef_type coef,
   input  logic [15:0]        raw_temp,
   output logic [31:0]        x1,
   output logic [31:0]        div_num,
   output logic [31:0]        div_den
);

   logic [31:0] diff_ff;
   logic [31:0] prod_ff;
   logic [31:0] prod_in;

   // Stage one registers ut - ac6, stage two the product with ac5.
   assign prod_in = diff_ff * coef.ac5;

   always_ff @(posedge clock) begin
      if (enable) begin
         diff_ff <= {16'd0, raw_temp} - coef.ac6;
         prod_ff <= prod_in;
      end
   end

   assign x1 = btpc_pkg::asr32(prod_ff, 15);
   assign div_num = coef.mc << 11;
   assign div_den = x1 + coef.md;

endmodule
